/* sv/assert_macros.svh */
// Assertion macros shared by the huber loss gradient block.
// Assertions compile away when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* sv/hlg_pkg.sv */
// Package of the huber loss gradient block: widths, reset values, codes, types.
// Used by the controller, the datapath, the divider and the top level.
package hlg_pkg;

  localparam int DATA_W     = 32;
  localparam int DELTA_W    = 31;
  localparam int COUNT_W    = 17;
  localparam int SUM_W      = 64;
  localparam int TERM_SHIFT = 17;
  localparam int NLIM_W     = 25;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int unsigned MAX_ELEMENTS_DEF = 65536;

  localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  typedef enum logic [0:0] {
    CFG_HUBER_DELTA   = 1'b0,
    CFG_ELEMENT_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_ACC,
    ST_GDIV,
    ST_MDIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic term_en;
    logic acc_en;
    logic gdiv_start;
    logic grad_save;
    logic mdiv_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage

/* sv/hlg_in_if.sv */
// Input channel of the huber loss gradient block: one prediction/target beat.
// Standalone; no package dependency.
interface hlg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pred_value;
  logic signed [31:0] target_value;
  logic               last_element;

  modport source (output valid, pred_value, target_value, last_element, input ready);
  modport sink (input valid, pred_value, target_value, last_element, output ready);
endinterface

/* sv/hlg_out_if.sv */
// Result channel of the huber loss gradient block: gradient and batch mean loss.
// Standalone; no package dependency.
interface hlg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grad_value;
  logic        [31:0] loss_mean;
  logic               loss_valid;

  modport source (output valid, grad_value, loss_mean, loss_valid, input ready);
  modport sink (input valid, grad_value, loss_mean, loss_valid, output ready);
endinterface

/* sv/hlg_div.sv */
// Shared restoring divider: 32 quotient bits by a 17-bit divisor, one bit a cycle.
// Depends on hlg_pkg.
module hlg_div
  import hlg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COUNT_W-1:0] rem_init,
  input  logic [DATA_W-1:0]  dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [DATA_W-1:0]  quotient
);

  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     diff;
  logic                 ge;

  always_comb begin
    trial    = {rem_r, quo_r[DATA_W-1]};
    diff     = trial - {1'b0, divisor};
    ge       = trial >= {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = rem_init;
      quo_nxt = dividend;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_nxt  = {quo_r[DATA_W-2:0], ge};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/hlg_ctrl.sv */
// Controller of the huber loss gradient block: sequences capture, loss term,
// gradient and mean divisions and the output load. Depends on hlg_pkg.
module hlg_ctrl
  import hlg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_TERM;
      end
      ST_TERM: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_GDIV;
      ST_GDIV: begin
        if (sts.div_done) state_nxt = sts.last ? ST_MDIV : ST_DONE;
      end
      ST_MDIV: begin
        if (sts.div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_TERM: cmd.term_en = 1'b1;
      ST_ACC: begin
        cmd.acc_en     = 1'b1;
        cmd.gdiv_start = 1'b1;
      end
      ST_GDIV: begin
        cmd.grad_save  = sts.div_done;
        cmd.mdiv_start = sts.div_done && sts.last;
      end
      ST_MDIV: ;
      ST_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* sv/hlg_dp.sv */
// Datapath of the huber loss gradient block: configuration registers, difference,
// loss term, saturating sum, divider and output register. Depends on hlg_pkg, hlg_div.
module hlg_dp
  import hlg_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [DELTA_W-1:0]       cfg_data,
  input  logic signed [DATA_W-1:0] pred_value,
  input  logic signed [DATA_W-1:0] target_value,
  input  logic                     last_element,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] grad_value,
  output logic [DATA_W-1:0]        loss_mean,
  output logic                     loss_valid,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts
);

  localparam logic [NLIM_W-1:0] MAX_N = NLIM_W'(MAX_ELEMENTS);

  logic [DELTA_W-1:0] delta_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] n_eff;

  logic [DATA_W-1:0] mag_r;
  logic              neg_r;
  logic              last_r;
  logic [SUM_W-1:0]  prod_r;
  logic [DATA_W-1:0] num_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0] grad_r;
  logic              sat_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_grad_r;
  logic [DATA_W-1:0] out_mean_r;
  logic              out_last_r;

  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] d_sat;
  logic [DATA_W-1:0] mag_in;
  logic              in_range;
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W:0]   mul_b;
  logic [SUM_W:0]    sum_add;
  logic [DATA_W-1:0] sum_hi;
  logic              mean_fits;

  logic               div_start;
  logic [COUNT_W-1:0] div_rem_init;
  logic [DATA_W-1:0]  div_dividend;
  logic               div_busy;
  logic               div_done;
  logic [DATA_W-1:0]  div_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RESET;
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HUBER_DELTA:   delta_r <= cfg_data;
        CFG_ELEMENT_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if ({{(NLIM_W-COUNT_W){1'b0}}, count_r} > MAX_N) begin
      n_eff = MAX_N[COUNT_W-1:0];
    end else begin
      n_eff = count_r;
    end
  end

  always_comb begin
    diff = {pred_value[DATA_W-1], pred_value} - {target_value[DATA_W-1], target_value};
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      d_sat = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      d_sat = diff[DATA_W-1:0];
    end
    mag_in = d_sat[DATA_W-1] ? (~d_sat + DATA_W'(1)) : d_sat;
  end

  always_comb begin
    in_range = {1'b0, delta_r} >= mag_r;
    if (in_range) begin
      mul_a = mag_r;
      mul_b = {1'b0, mag_r};
    end else begin
      mul_a = {1'b0, delta_r};
      mul_b = {mag_r, 1'b0} - {2'b00, delta_r};
    end
  end

  always_comb begin
    sum_add = {1'b0, sum_r} + {{(TERM_SHIFT+1){1'b0}}, prod_r[SUM_W-1:TERM_SHIFT]};
    sum_nxt = sum_r;
    priority if (cmd.out_load && last_r) begin
      sum_nxt = '0;
    end else if (cmd.acc_en) begin
      sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_r  <= mag_in;
      neg_r  <= d_sat[DATA_W-1];
      last_r <= last_element;
    end
    if (cmd.term_en) begin
      prod_r <= SUM_W'(mul_a * mul_b);
      num_r  <= in_range ? mag_r : {1'b0, delta_r};
    end
    if (cmd.grad_save) begin
      grad_r <= neg_r ? (DATA_W'(0) - div_quo) : div_quo;
    end
    if (cmd.mdiv_start) begin
      sat_r <= !mean_fits;
    end
  end

  assign sum_hi       = sum_r[SUM_W-1:DATA_W];
  assign mean_fits    = sum_hi < {{(DATA_W-COUNT_W){1'b0}}, n_eff};
  assign div_start    = cmd.gdiv_start || cmd.mdiv_start;
  assign div_rem_init = (cmd.mdiv_start && mean_fits) ? sum_hi[COUNT_W-1:0] : '0;
  assign div_dividend = cmd.mdiv_start ? sum_r[DATA_W-1:0] : num_r;

  hlg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_grad_r <= grad_r;
      out_last_r <= last_r;
      if (!last_r) begin
        out_mean_r <= '0;
      end else begin
        out_mean_r <= sat_r ? '1 : div_quo;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign grad_value = out_grad_r;
  assign loss_mean  = out_mean_r;
  assign loss_valid = out_last_r;

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

/* sv/huber_loss_gradient.sv */
// Huber loss gradient: each input beat yields one result beat with the gradient
// d/n (or +-delta/n beyond the threshold), and on the last beat of a batch also
// the mean loss. The block accepts no new beat while an element is in flight,
// and a last element holds it longer, because the gradient and the mean each
// pass through one shared divider that produces one quotient bit per cycle. A
// finished result waits in an output register while the next beat is accepted;
// the block only stalls further when that register still holds a beat that has
// not been taken.
`include "assert_macros.svh"

module huber_loss_gradient
  import hlg_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [DELTA_W-1:0] cfg_data,
  hlg_in_if.sink             in_ch,
  hlg_out_if.source          out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hlg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlg_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pred_value   (in_ch.pred_value),
    .target_value (in_ch.target_value),
    .last_element (in_ch.last_element),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .grad_value   (out_ch.grad_value),
    .loss_mean    (out_ch.loss_mean),
    .loss_valid   (out_ch.loss_valid),
    .cmd          (cmd),
    .sts          (sts)
  );

  `ASSERT_NEVER(a_ready_while_dividing, clk, rst_n, in_ch.ready && sts.div_busy)
  `ASSERT_PROP(a_accept_drops_ready, clk, rst_n, in_ch.valid && in_ch.ready |=> !in_ch.ready)
  `ASSERT_PROP(a_mean_only_on_last, clk, rst_n, out_ch.valid && !out_ch.loss_valid |-> out_ch.loss_mean == 0)

endmodule
